FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; every macro expects a clock and an active-high reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/utf8d_pkg.sv
// Shared types and constants of the UTF-8 character decoder.
// Depends on nothing; used by every module of the block.
`default_nettype none

package utf8d_pkg;

  typedef struct packed {
    logic [7:0] byte_0;
    logic [7:0] byte_1;
    logic [7:0] byte_2;
    logic [7:0] byte_3;
    logic [7:0] byte_4;
    logic [7:0] byte_5;
    logic [2:0] avail_bytes;
  } win_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic [2:0]  seq_length;
    logic        status;
  } res_t;

  localparam logic STATUS_LEGAL   = 1'b0;
  localparam logic STATUS_ILLEGAL = 1'b1;

  localparam logic [2:0] MAX_BYTES = 3'd6;

  // Leads that constrain the second byte.
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F8 = 8'hF8;
  localparam logic [7:0] LEAD_FC = 8'hFC;

  localparam logic [7:0] MIN_AFTER_E0 = 8'hA0;
  localparam logic [7:0] MAX_AFTER_ED = 8'h9F;
  localparam logic [7:0] MIN_AFTER_F0 = 8'h90;
  localparam logic [7:0] MIN_AFTER_F8 = 8'h88;
  localparam logic [7:0] MIN_AFTER_FC = 8'h84;

  localparam logic [7:0] CONT_LOW  = 8'h80;
  localparam logic [7:0] CONT_HIGH = 8'hBF;

endpackage

`default_nettype wire

FILE: rtl/utf8d_in_reg.sv
// Input register stage: holds one window word and its valid flag.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            win_valid,
  input  wire utf8d_pkg::win_t win,
  output logic                 held_valid,
  output utf8d_pkg::win_t      held
);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= win_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && win_valid) begin
      held <= win;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf8d_decode.sv
// Combinational decode and validation of the first character of a window.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_decode (
  input  wire utf8d_pkg::win_t win,
  output utf8d_pkg::res_t      res
);

  logic [7:0]  b [6];
  logic [2:0]  avail;
  logic [2:0]  len;
  logic        cont_ok;
  logic        second_ok;
  logic [30:0] cp;

  always_comb begin
    b[0] = win.byte_0;
    b[1] = win.byte_1;
    b[2] = win.byte_2;
    b[3] = win.byte_3;
    b[4] = win.byte_4;
    b[5] = win.byte_5;
    avail = (win.avail_bytes > utf8d_pkg::MAX_BYTES) ? utf8d_pkg::MAX_BYTES
                                                     : win.avail_bytes;

    case (b[0]) inside
      [8'h00:8'h7F]: len = 3'd1;
      [8'hC2:8'hDF]: len = 3'd2;
      [8'hE0:8'hEF]: len = 3'd3;
      [8'hF0:8'hF7]: len = 3'd4;
      [8'hF8:8'hFB]: len = 3'd5;
      [8'hFC:8'hFD]: len = 3'd6;
      default:       len = 3'd0;
    endcase

    // trailing bytes only matter up to the decoded length
    cont_ok = 1'b1;
    for (int i = 1; i < 6; i++) begin
      if ((3'(i) < len) &&
          ((b[i] < utf8d_pkg::CONT_LOW) || (b[i] > utf8d_pkg::CONT_HIGH))) begin
        cont_ok = 1'b0;
      end
    end

    case (b[0])
      utf8d_pkg::LEAD_E0: second_ok = (b[1] >= utf8d_pkg::MIN_AFTER_E0);
      utf8d_pkg::LEAD_ED: second_ok = (b[1] <= utf8d_pkg::MAX_AFTER_ED);
      utf8d_pkg::LEAD_F0: second_ok = (b[1] >= utf8d_pkg::MIN_AFTER_F0);
      utf8d_pkg::LEAD_F8: second_ok = (b[1] >= utf8d_pkg::MIN_AFTER_F8);
      utf8d_pkg::LEAD_FC: second_ok = (b[1] >= utf8d_pkg::MIN_AFTER_FC);
      default:            second_ok = 1'b1;
    endcase

    case (len)
      3'd1:    cp = {24'd0, b[0][6:0]};
      3'd2:    cp = {20'd0, b[0][4:0], b[1][5:0]};
      3'd3:    cp = {15'd0, b[0][3:0], b[1][5:0], b[2][5:0]};
      3'd4:    cp = {10'd0, b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
      3'd5:    cp = {5'd0, b[0][1:0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0]};
      3'd6:    cp = {b[0][0], b[1][5:0], b[2][5:0], b[3][5:0], b[4][5:0], b[5][5:0]};
      default: cp = 31'd0;
    endcase

    if ((len != 3'd0) && (len <= avail) && cont_ok && second_ok) begin
      res.code_point = cp;
      res.seq_length = len;
      res.status     = utf8d_pkg::STATUS_LEGAL;
    end else begin
      res.code_point = 31'd0;
      res.seq_length = 3'd0;
      res.status     = utf8d_pkg::STATUS_ILLEGAL;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf8d_out_reg.sv
// Result register stage: holds one decoded result word until it is taken.
// Depends on utf8d_pkg.
`default_nettype none

module utf8d_out_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire logic            next_valid,
  input  wire utf8d_pkg::res_t next_res,
  output logic                 res_valid,
  output utf8d_pkg::res_t      res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= next_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && next_valid) begin
      res <= next_res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/utf8_char_decode_validate_unit.sv
// Top level of the UTF-8 character decoder: input register, decode, result register.
// Depends on utf8d_pkg, utf8d_in_reg, utf8d_decode and utf8d_out_reg.
//
//   channel  direction  handshake             word
//   win      in         win_valid/win_stall   utf8d_pkg::win_t
//   res      out        res_valid/res_stall   utf8d_pkg::res_t
//
// One window word per cycle while win_stall is low; an accepted word passes the
// input register, then the result register behind the decode logic.
// rst is synchronous and clears both stage valid flags only.
// res_stall holds the result register; the input register then holds too and
// win_stall rises in the same cycle once the input register is occupied.
`default_nettype none

module utf8_char_decode_validate_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            win_valid,
  output logic                 win_stall,
  input  wire utf8d_pkg::win_t win,
  output logic                 res_valid,
  input  wire logic            res_stall,
  output utf8d_pkg::res_t      res
);

  logic            held_valid;
  utf8d_pkg::win_t held;
  utf8d_pkg::res_t dec_res;
  logic            out_load;
  logic            in_load;

  assign out_load  = !res_valid || !res_stall;
  assign in_load   = !held_valid || out_load;
  assign win_stall = !in_load;

  utf8d_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .load       (in_load),
    .win_valid  (win_valid),
    .win        (win),
    .held_valid (held_valid),
    .held       (held)
  );

  utf8d_decode u_dec (
    .win (held),
    .res (dec_res)
  );

  utf8d_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (out_load),
    .next_valid (held_valid),
    .next_res   (dec_res),
    .res_valid  (res_valid),
    .res        (res)
  );

endmodule

`default_nettype wire

FILE: rtl/utf8d_checker.sv
// Port-level checks on the UTF-8 character decoder, bound to the top level.
// Depends on utf8d_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module utf8d_checker (
  input wire logic            clk,
  input wire logic            rst,
  input wire logic            win_stall,
  input wire logic            res_valid,
  input wire logic            res_stall,
  input wire utf8d_pkg::res_t res
);

  logic res_legal;
  logic res_zero;
  logic len_in_range;
  logic ascii_word;
  logic ascii_narrow;

  assign res_legal    = res.status == utf8d_pkg::STATUS_LEGAL;
  assign res_zero     = (res.code_point == 31'd0) && (res.seq_length == 3'd0);
  assign len_in_range = (res.seq_length != 3'd0) &&
                        (res.seq_length <= utf8d_pkg::MAX_BYTES);
  assign ascii_word   = res_valid && res_legal && (res.seq_length == 3'd1);
  assign ascii_narrow = res.code_point[30:7] == 24'd0;

  `ASSERT_NEXT(a_res_hold, clk, rst, res_valid && res_stall, res_valid && $stable(res))
  `ASSERT_SAME(a_illegal_zero, clk, rst, res_valid && !res_legal, res_zero)
  `ASSERT_SAME(a_legal_len, clk, rst, res_valid && res_legal, len_in_range)
  `ASSERT_SAME(a_ascii_narrow, clk, rst, ascii_word, ascii_narrow)
  // no back-pressure on the input while the output side keeps draining
  `ASSERT_SAME(a_no_stall, clk, rst, !res_stall, !win_stall)

endmodule

bind utf8_char_decode_validate_unit utf8d_checker u_chk (.*);

`default_nettype wire
